// ===== rtl/wfc_pkg.sv =====
// Shared types, constants and helper functions of the wide integer to float converter.
package wfc_pkg;

	// Widths and format constants.
	localparam int LIMB_W   = 64;
	localparam int LEN_W    = 10;
	localparam int DBL_MANT = 53;
	localparam int SGL_MANT = 24;
	localparam int TOP_W    = DBL_MANT + 1;

	localparam logic [10:0] DBL_BIAS = 11'd1023;
	localparam logic [7:0]  SGL_BIAS = 8'd127;
	localparam logic [31:0] SGL_INF  = 32'h7F80_0000;

	// Target format codes.
	typedef enum logic {
		FMT_DOUBLE = 1'b0,
		FMT_SINGLE = 1'b1
	} fmt_t;

	// Normalised magnitude handed to the rounding and packing logic.
	typedef struct packed {
		logic             neg;
		logic             zero;
		fmt_t             fmt;
		logic [LEN_W-1:0] len;
		logic [TOP_W-1:0] top;
		logic             sticky_d;
		logic             sticky_s;
	} norm_t;

	// Position of the highest set bit of a limb; the limb is known to be non-zero.
	function automatic logic [5:0] msb64(input logic [LIMB_W-1:0] v);
		logic [5:0] pos;
		pos = '0;
		for (int i = 0; i < LIMB_W; i++) begin
			if (v[i]) begin
				pos = 6'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== rtl/wide_integer_to_float_core.sv =====
// Top level of the wide integer to IEEE-754 float converter.
// Converts a NUM_LIMBS x 64-bit integer, signed or unsigned, to double or single
// precision with round to nearest, ties to even. The block takes one item every
// cycle while the output does not stall; the first stage forms the magnitude
// with a full-width negate, the second finds the bit length by a per-limb
// priority encode, the third aligns the leading one with a barrel shifter and
// collects sticky bits, and the result register holds the rounded, packed bits.
// All stages advance together whenever the result register is empty or its
// item is being taken, so a stall on the output holds the whole pipeline.
module wide_integer_to_float_core #(
	parameter int NUM_LIMBS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic        as_unsigned,
	input  logic [63:0] limb0,
	input  logic [63:0] limb1,
	input  logic [63:0] limb2,
	input  logic [63:0] limb3,
	input  logic [63:0] limb4,
	input  logic [63:0] limb5,
	input  logic [63:0] limb6,
	input  logic [63:0] limb7,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] float_bits
);
	import wfc_pkg::*;

	localparam int W = LIMB_W * NUM_LIMBS;

	logic              en;
	logic [LIMB_W-1:0] lim [8];
	logic [W-1:0]      raw;
	logic              neg_in;

	logic              v_s1, v_s2, v_s3, out_valid_q;
	logic [W-1:0]      mag_s1, mag_s2;
	logic              neg_s1, neg_s2;
	fmt_t              fmt_s1, fmt_s2;
	logic [LEN_W-1:0]  len_d, len_s2;
	logic              zero_d, zero_s2;
	logic [LEN_W-1:0]  sh;
	logic [W-1:0]      aligned;
	norm_t             nrm_s3;
	logic [63:0]       bits_d, bits_q;

	// The whole pipeline moves when the result register can take a new item.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Gather the limbs that the configured width uses.
	always_comb begin
		lim = '{limb0, limb1, limb2, limb3, limb4, limb5, limb6, limb7};
		for (int i = 0; i < NUM_LIMBS; i++) begin
			raw[i*LIMB_W +: LIMB_W] = lim[i];
		end
		neg_in = !as_unsigned && raw[W-1];
	end

	// Stage 1: magnitude of the integer.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= neg_in ? (~raw + W'(1)) : raw;
			neg_s1 <= neg_in;
			fmt_s1 <= fmt_t'(op);
		end
	end

	// Bit length from the highest non-zero limb.
	always_comb begin
		len_d  = '0;
		zero_d = 1'b1;
		for (int i = 0; i < NUM_LIMBS; i++) begin
			if (mag_s1[i*LIMB_W +: LIMB_W] != '0) begin
				len_d  = LEN_W'(i * LIMB_W) + LEN_W'(msb64(mag_s1[i*LIMB_W +: LIMB_W])) +
				         LEN_W'(1);
				zero_d = 1'b0;
			end
		end
	end

	// Stage 2: magnitude with its bit length.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			fmt_s2  <= fmt_s1;
			len_s2  <= len_d;
			zero_s2 <= zero_d;
		end
	end

	// Move the leading one to the top bit.
	assign sh      = LEN_W'(W) - len_s2;
	assign aligned = mag_s2 << sh;

	// Stage 3: kept bits, round bit and sticky bits for both formats.
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s3.neg      <= neg_s2;
			nrm_s3.zero     <= zero_s2;
			nrm_s3.fmt      <= fmt_s2;
			nrm_s3.len      <= len_s2;
			nrm_s3.top      <= aligned[W-1 -: TOP_W];
			nrm_s3.sticky_d <= |aligned[W-TOP_W-1:0];
			nrm_s3.sticky_s <= |aligned[W-SGL_MANT-2:0];
		end
	end

	wfc_pack u_pack (
		.nrm  (nrm_s3),
		.bits (bits_d)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			bits_q <= bits_d;
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign float_bits = bits_q;

	// An item in the last stage reaches the result register when the pipeline moves.
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en |=> out_valid_q)
		else $error("item lost between stage 3 and result register");

	// A zero magnitude packs to positive zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en && nrm_s3.zero |=> float_bits == 64'd0)
		else $error("zero item did not give positive zero");

	// Single results leave the upper word clear.
	a_sgl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en && nrm_s3.fmt == FMT_SINGLE |=> float_bits[63:32] == 32'd0)
		else $error("single result has upper bits set");

	// A non-zero magnitude has its leading one at the top after alignment.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !nrm_s3.zero |-> nrm_s3.top[TOP_W-1])
		else $error("aligned magnitude not normalised");

endmodule

// ===== rtl/wfc_pack.sv =====
// Round to nearest even and packing of the IEEE-754 result bits.
module wfc_pack (
	input  wfc_pkg::norm_t  nrm,
	output logic [63:0]     bits
);
	import wfc_pkg::*;

	logic [DBL_MANT-1:0] sig_d;
	logic [DBL_MANT:0]   sum_d;
	logic                inc_d;
	logic [SGL_MANT-1:0] sig_s;
	logic [SGL_MANT:0]   sum_s;
	logic                inc_s;
	logic [LEN_W-1:0]    exp_d;
	logic [LEN_W-1:0]    exp_s;
	logic [10:0]         bexp_d;
	logic [7:0]          bexp_s;
	logic [31:0]         res_s;

	// Double: keep 53 bits, round with the next bit and the sticky of the rest.
	always_comb begin
		sig_d  = nrm.top[TOP_W-1 -: DBL_MANT];
		inc_d  = nrm.top[TOP_W-DBL_MANT-1] & (nrm.sticky_d | sig_d[0]);
		sum_d  = {1'b0, sig_d} + {{DBL_MANT{1'b0}}, inc_d};
		exp_d  = sum_d[DBL_MANT] ? nrm.len : nrm.len - LEN_W'(1);
		bexp_d = 11'(exp_d) + DBL_BIAS;
	end

	// Single: keep 24 bits; a carry out of the significand raises the exponent.
	always_comb begin
		sig_s  = nrm.top[TOP_W-1 -: SGL_MANT];
		inc_s  = nrm.top[TOP_W-SGL_MANT-1] & (nrm.sticky_s | sig_s[0]);
		sum_s  = {1'b0, sig_s} + {{SGL_MANT{1'b0}}, inc_s};
		exp_s  = sum_s[SGL_MANT] ? nrm.len : nrm.len - LEN_W'(1);
		bexp_s = exp_s[7:0] + SGL_BIAS;
		if (exp_s >= LEN_W'(128)) begin
			res_s = SGL_INF;
		end else begin
			res_s = {1'b0, bexp_s, sum_s[SGL_MANT] ? 23'd0 : sum_s[SGL_MANT-2:0]};
		end
		res_s[31] = nrm.neg;
	end

	// Select the format; zero always gives positive zero.
	always_comb begin
		if (nrm.zero) begin
			bits = '0;
		end else if (nrm.fmt == FMT_SINGLE) begin
			bits = {32'd0, res_s};
		end else begin
			bits = {nrm.neg, bexp_d, sum_d[DBL_MANT] ? 52'd0 : sum_d[DBL_MANT-2:0]};
		end
	end

endmodule

// ===== tb/wide_integer_to_float_core_tb.sv =====
// Self-checking testbench for the wide integer to IEEE-754 float converter.
module wide_integer_to_float_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wfc_pkg::*;

	localparam int NLIMBS = 8;
	localparam int NBITS = NLIMBS * 64;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic as_unsigned;
	logic [63:0] limb [8];
	logic out_valid;
	logic out_ready;
	logic [63:0] float_bits;

	logic [63:0] expected_floats [$];
	int mismatches;
	longint cycles;
	bit sending_done;
	int rx_wait;

	wide_integer_to_float_core #(.NUM_LIMBS(NLIMBS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .as_unsigned(as_unsigned),
		.limb0(limb[0]), .limb1(limb[1]), .limb2(limb[2]), .limb3(limb[3]),
		.limb4(limb[4]), .limb5(limb[5]), .limb6(limb[6]), .limb7(limb[7]),
		.out_valid(out_valid), .out_ready(out_ready), .float_bits(float_bits)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Converts a wide integer to float bits with round to nearest, ties to even.
	function automatic logic [63:0] convert_to_float(input fmt_t fmt, input logic uns,
			input logic [NBITS-1:0] value);
		logic [NBITS-1:0] mag;
		logic neg;
		int len;
		int mant;
		int shift;
		logic [63:0] head;
		logic sticky;
		logic rnd;
		int expo;
		logic [63:0] res;
		neg = !uns && value[NBITS-1];
		mag = neg ? (~value + 1'b1) : value;
		len = 0;
		for (int i = 0; i < NBITS; i++) begin
			if (mag[i]) begin
				len = i + 1;
			end
		end
		if (len == 0) begin
			return 64'd0;
		end
		mant = (fmt == FMT_SINGLE) ? SGL_MANT : DBL_MANT;
		expo = len - 1;
		if (len <= mant) begin
			head = 64'(mag) << (mant - len);
		end else begin
			shift = len - (mant + 1);
			head = 64'(mag >> shift);
			sticky = (mag & ((NBITS'(1) << shift) - 1'b1)) != '0;
			rnd = head[0];
			head = head >> 1;
			if (rnd && (sticky || head[0])) begin
				head = head + 1;
			end
			if (head == (64'd1 << mant)) begin
				head = head >> 1;
				expo = len;
			end
		end
		head = head & ((64'd1 << (mant - 1)) - 1);
		if (fmt == FMT_SINGLE) begin
			if (expo >= 128) begin
				res = {32'd0, SGL_INF};
			end else begin
				res = (64'(expo + 127) << 23) | head;
			end
			if (neg) begin
				res[31] = 1'b1;
			end
		end else begin
			res = (64'(expo + 1023) << 52) | head;
			if (neg) begin
				res[63] = 1'b1;
			end
		end
		return res;
	endfunction

	// Sends one item, records its expected float, then idles for a random gap.
	task automatic send_item(input fmt_t fmt, input logic uns, input logic [NBITS-1:0] value);
		int gap;
		in_valid <= 1'b1;
		op <= fmt;
		as_unsigned <= uns;
		for (int i = 0; i < NLIMBS; i++) begin
			limb[i] <= value[i*64 +: 64];
		end
		expected_floats.push_back(convert_to_float(fmt, uns, value));
		do @(posedge clk); while (!in_ready);
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random integer whose significant length is drawn, so all exponents appear.
	function automatic logic [NBITS-1:0] random_value();
		logic [NBITS-1:0] v;
		int len;
		for (int i = 0; i < NBITS; i += 32) begin
			v[i +: 32] = $urandom;
		end
		len = $urandom_range(1, NBITS);
		if (len < NBITS) begin
			v = v & ((NBITS'(1) << len) - 1'b1);
		end
		case ($urandom_range(0, 5))
			0: v = v & ~((NBITS'(1) << $urandom_range(0, 60)) - 1'b1);
			1: v = v | ((NBITS'(1) << $urandom_range(0, 60)) - 1'b1);
			2: v = ~v;
			default: ;
		endcase
		return v;
	endfunction

	// Boundary values: zero, ones, the most negative value, exact fits and ties.
	task automatic test_directed();
		logic [NBITS-1:0] tie;
		send_item(FMT_DOUBLE, 1'b1, '0);
		send_item(FMT_SINGLE, 1'b0, '0);
		send_item(FMT_DOUBLE, 1'b1, '1);
		send_item(FMT_SINGLE, 1'b1, '1);
		send_item(FMT_DOUBLE, 1'b0, '1);
		send_item(FMT_SINGLE, 1'b0, '1);
		send_item(FMT_DOUBLE, 1'b0, NBITS'(1) << (NBITS - 1));
		send_item(FMT_SINGLE, 1'b0, NBITS'(1) << (NBITS - 1));
		send_item(FMT_DOUBLE, 1'b1, NBITS'(1) << (NBITS - 1));
		send_item(FMT_SINGLE, 1'b1, NBITS'(1) << 128);
		send_item(FMT_SINGLE, 1'b1, (NBITS'(1) << 128) - 1'b1);
		send_item(FMT_SINGLE, 1'b0, (NBITS'(1) << 127));
		send_item(FMT_DOUBLE, 1'b1, (NBITS'(1) << 53) - 1'b1);
		send_item(FMT_DOUBLE, 1'b1, (NBITS'(1) << 54) - 1'b1);
		send_item(FMT_SINGLE, 1'b1, NBITS'(24'hFFFFFF));
		// Halfway cases round to even, both down and up; one single case has sticky bits but a clear round bit.
		tie = (NBITS'(1) << 53) | 1'b1;
		send_item(FMT_DOUBLE, 1'b1, tie);
		send_item(FMT_DOUBLE, 1'b1, tie | 2'b10);
		send_item(FMT_SINGLE, 1'b1, NBITS'(25'h1000001));
		send_item(FMT_SINGLE, 1'b1, NBITS'(25'h1000003));
		send_item(FMT_SINGLE, 1'b1, NBITS'(64'h0000_0001_0000_0081));
		send_item(FMT_DOUBLE, 1'b0, NBITS'(1));
		send_item(FMT_SINGLE, 1'b0, '1 << 1);
	endtask

	// Stops sending and waits until every expected float has been delivered.
	task automatic test_drain_pause();
		in_valid <= 1'b0;
		wait (expected_floats.size() == 0);
		@(posedge clk);
	endtask

	// Random items over both formats and both signedness modes.
	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_item(fmt_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_value());
		end
	endtask

	// Receiver stalls for a random wait per item and compares each float
	// with the oldest expectation.
	always @(posedge clk) begin
		logic [63:0] want;
		if (out_valid && out_ready) begin
			if (expected_floats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected item: float_bits=%h", float_bits);
				end
			end else begin
				want = expected_floats.pop_front();
				if (float_bits !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %h, got %h", want, float_bits);
					end
				end
			end
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rx_wait = sending_done ? 0 : $urandom_range(0, 8);
			end else if (out_valid && rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	// Guards against a hang.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** wide_integer_to_float_core: FAILED **");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		sending_done = 1'b0;
		rx_wait = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		op = 1'b0;
		as_unsigned = 1'b0;
		for (int i = 0; i < 8; i++) begin
			limb[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random(360);
		test_drain_pause();
		test_random(360);
		sending_done = 1'b1;
		test_drain_pause();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_floats.size() == 0) begin
			$display("** wide_integer_to_float_core: PASSED **");
		end else begin
			$display("** wide_integer_to_float_core: FAILED **");
		end
		$finish;
	end
endmodule
